@@ rtl/pbary_pkg.sv @@
`timescale 1ns / 1ps
package pbary_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS = 12;
	localparam int W_WIDTH = COORD_WIDTH - 1;
	// Edge and offset differences.
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	// Cross products: area S and the edge functions A and B.
	localparam int AREA_WIDTH = 2 * DIFF_WIDTH + 1;
	// Product of two vertex w values.
	localparam int WW_WIDTH = 2 * W_WIDTH;
	// Weighted numerators and the interpolated denominator.
	localparam int NUM_WIDTH = AREA_WIDTH + 2 + WW_WIDTH + 1;
	// Quotient magnitude bits that are resolved by the divider.
	localparam int QUOT_BITS = COORD_WIDTH + 1;
	// Dividend holds the numerator scaled by 2^(FRAC_BITS+1) plus the denominator.
	localparam int DIVD_WIDTH = NUM_WIDTH + FRAC_BITS + 2;
	localparam int DIV_STEPS = QUOT_BITS;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_CULLED = 2'd1,
		ST_DEGEN = 2'd2,
		ST_SAT = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] sample_x;
		logic signed [COORD_WIDTH-1:0] sample_y;
		logic signed [COORD_WIDTH-1:0] first_x;
		logic signed [COORD_WIDTH-1:0] first_y;
		logic [W_WIDTH-1:0] first_w;
		logic signed [COORD_WIDTH-1:0] second_x;
		logic signed [COORD_WIDTH-1:0] second_y;
		logic [W_WIDTH-1:0] second_w;
		logic signed [COORD_WIDTH-1:0] third_x;
		logic signed [COORD_WIDTH-1:0] third_y;
		logic [W_WIDTH-1:0] third_w;
	} item_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] persp_i;
		logic signed [COORD_WIDTH-1:0] persp_j;
		status_t status;
	} result_t;

endpackage

@@ rtl/perspective_barycentric.sv @@
`timescale 1ns / 1ps
// A start transfer passes through stages 1 to 6, the divider stages and the final stage
// before the result strobe.
// Throughput: one item per clock; busy is held low, and the receiver cannot stall.
// Reset: arst_n clears the valid bits of every stage and the cull register;
// data registers are not reset.
module perspective_barycentric (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input pbary_pkg::item_t item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data,
	output logic result_valid,
	output pbary_pkg::result_t result
);

	localparam int CW = pbary_pkg::COORD_WIDTH;
	localparam int DW = pbary_pkg::DIFF_WIDTH;
	localparam int AW = pbary_pkg::AREA_WIDTH;
	localparam int WW = pbary_pkg::WW_WIDTH;
	localparam int NW = pbary_pkg::NUM_WIDTH;
	localparam int VW = pbary_pkg::DIVD_WIDTH;
	localparam int QB = pbary_pkg::QUOT_BITS;
	localparam int FB = pbary_pkg::FRAC_BITS;
	localparam int NS = pbary_pkg::DIV_STEPS;

	// The pipeline never stalls, so every cycle can take an item.
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	logic cull_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			cull_q <= cfg_data;
		end
	end

	wire accept = start && !busy;

	// Stage 1: differences from the first vertex, and the sampled cull mode.
	logic v_s1, cull_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, ax_s1, ay_s1, bx_s1, by_s1;
	logic [pbary_pkg::W_WIDTH-1:0] w1_s1, w2_s1, w3_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end
	always_ff @(posedge clk) begin
		cull_s1 <= cull_q;
		dx_s1 <= DW'(item.sample_x) - DW'(item.first_x);
		dy_s1 <= DW'(item.sample_y) - DW'(item.first_y);
		ax_s1 <= DW'(item.second_x) - DW'(item.first_x);
		ay_s1 <= DW'(item.second_y) - DW'(item.first_y);
		bx_s1 <= DW'(item.third_x) - DW'(item.first_x);
		by_s1 <= DW'(item.third_y) - DW'(item.first_y);
		w1_s1 <= item.first_w;
		w2_s1 <= item.second_w;
		w3_s1 <= item.third_w;
	end

	// Stage 2: the six cross-product terms and the three w products.
	logic v_s2, cull_s2;
	logic signed [2*DW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic [WW-1:0] w13_s2, w12_s2, w23_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		cull_s2 <= cull_s1;
		p0_s2 <= ax_s1 * by_s1;
		p1_s2 <= ay_s1 * bx_s1;
		p2_s2 <= dx_s1 * by_s1;
		p3_s2 <= dy_s1 * bx_s1;
		p4_s2 <= dy_s1 * ax_s1;
		p5_s2 <= dx_s1 * ay_s1;
		w13_s2 <= w1_s1 * w3_s1;
		w12_s2 <= w1_s1 * w2_s1;
		w23_s2 <= w2_s1 * w3_s1;
	end

	// Stage 3: area S, edge functions A and B, and K = S - A - B.
	logic v_s3, cull_s3;
	logic signed [AW-1:0] s_s3, a_s3, b_s3;
	logic signed [AW+1:0] k_s3;
	logic [WW-1:0] w13_s3, w12_s3, w23_s3;
	logic signed [AW-1:0] s_c, a_c, b_c;
	assign s_c = AW'(p0_s2) - AW'(p1_s2);
	assign a_c = AW'(p2_s2) - AW'(p3_s2);
	assign b_c = AW'(p4_s2) - AW'(p5_s2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		cull_s3 <= cull_s2;
		s_s3 <= s_c;
		a_s3 <= a_c;
		b_s3 <= b_c;
		k_s3 <= (AW+2)'(s_c) - (AW+2)'(a_c) - (AW+2)'(b_c);
		w13_s3 <= w13_s2;
		w12_s3 <= w12_s2;
		w23_s3 <= w23_s2;
	end

	// Stage 4: weighted numerators and the K term.
	logic v_s4, cull_s4, sneg_s4, szero_s4;
	logic signed [NW-1:0] ni_s4, nj_s4, nk_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		cull_s4 <= cull_s3;
		sneg_s4 <= s_s3[AW-1];
		szero_s4 <= (s_s3 == '0);
		ni_s4 <= NW'(a_s3) * $signed({1'b0, w13_s3});
		nj_s4 <= NW'(b_s3) * $signed({1'b0, w12_s3});
		nk_s4 <= NW'(k_s3) * $signed({1'b0, w23_s3});
	end

	// Stage 5: denominator D and the special cases.
	logic v_s5, sneg_i_s5, sneg_j_s5;
	logic [1:0] kind_s5; // status for culled or degenerate, else ok
	logic special_s5;
	logic [NW-1:0] mi_s5, mj_s5, md_s5;
	logic signed [NW-1:0] den_c;
	assign den_c = nk_s4 + ni_s4 + nj_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		sneg_i_s5 <= ni_s4[NW-1] ^ den_c[NW-1];
		sneg_j_s5 <= nj_s4[NW-1] ^ den_c[NW-1];
		mi_s5 <= ni_s4[NW-1] ? NW'(-ni_s4) : NW'(ni_s4);
		mj_s5 <= nj_s4[NW-1] ? NW'(-nj_s4) : NW'(nj_s4);
		md_s5 <= den_c[NW-1] ? NW'(-den_c) : NW'(den_c);
		if (cull_s4 && sneg_s4) begin
			special_s5 <= 1'b1;
			kind_s5 <= pbary_pkg::ST_CULLED;
		end else if (szero_s4 || den_c == '0) begin
			special_s5 <= 1'b1;
			kind_s5 <= pbary_pkg::ST_DEGEN;
		end else begin
			special_s5 <= 1'b0;
			kind_s5 <= pbary_pkg::ST_OK;
		end
	end

	// Stage 6: dividends n*2^(FB+1) + d over the divisor 2d; the overflow flag
	// records a quotient that does not fit in QB bits, that is 2^QB or more.
	logic v_s6, sneg_i_s6, sneg_j_s6, special_s6, ovi_s6, ovj_s6;
	logic [1:0] kind_s6;
	logic [VW-1:0] ri_s6, rj_s6, dd_s6;
	logic [VW-1:0] ni_c, nj_c, d2_c;
	assign ni_c = (VW'(mi_s5) << (FB + 1)) + VW'(md_s5);
	assign nj_c = (VW'(mj_s5) << (FB + 1)) + VW'(md_s5);
	assign d2_c = VW'(md_s5) << 1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		sneg_i_s6 <= sneg_i_s5;
		sneg_j_s6 <= sneg_j_s5;
		special_s6 <= special_s5;
		kind_s6 <= kind_s5;
		ri_s6 <= ni_c;
		rj_s6 <= nj_c;
		dd_s6 <= d2_c;
		ovi_s6 <= (ni_c >> QB) >= d2_c;
		ovj_s6 <= (nj_c >> QB) >= d2_c;
	end

	// Divider pipeline: one restoring step per stage, one quotient bit each.
	logic dv_v [NS+1];
	logic [VW-1:0] dv_ri [NS+1];
	logic [VW-1:0] dv_rj [NS+1];
	logic [VW-1:0] dv_d [NS+1];
	logic [QB-1:0] dv_qi [NS+1];
	logic [QB-1:0] dv_qj [NS+1];
	logic dv_ni [NS+1];
	logic dv_nj [NS+1];
	logic dv_sp [NS+1];
	logic dv_oi [NS+1];
	logic dv_oj [NS+1];
	logic [1:0] dv_k [NS+1];

	assign dv_v[0] = v_s6;
	assign dv_ri[0] = ri_s6;
	assign dv_rj[0] = rj_s6;
	assign dv_d[0] = dd_s6;
	assign dv_qi[0] = '0;
	assign dv_qj[0] = '0;
	assign dv_ni[0] = sneg_i_s6;
	assign dv_nj[0] = sneg_j_s6;
	assign dv_sp[0] = special_s6;
	assign dv_oi[0] = ovi_s6;
	assign dv_oj[0] = ovj_s6;
	assign dv_k[0] = kind_s6;

	for (genvar g = 0; g < NS; g++) begin : g_div
		localparam int SH = QB - 1 - g;
		logic [VW-1:0] ti, tj;
		logic gi, gj;
		assign ti = dv_d[g] << SH;
		assign tj = dv_d[g] << SH;
		assign gi = ((dv_ri[g] >> SH) >= dv_d[g]);
		assign gj = ((dv_rj[g] >> SH) >= dv_d[g]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[g+1] <= 1'b0;
			end else begin
				dv_v[g+1] <= dv_v[g];
			end
		end
		always_ff @(posedge clk) begin
			dv_ri[g+1] <= gi ? dv_ri[g] - ti : dv_ri[g];
			dv_rj[g+1] <= gj ? dv_rj[g] - tj : dv_rj[g];
			dv_qi[g+1] <= dv_qi[g] | (QB'(gi) << SH);
			dv_qj[g+1] <= dv_qj[g] | (QB'(gj) << SH);
			dv_d[g+1] <= dv_d[g];
			dv_ni[g+1] <= dv_ni[g];
			dv_nj[g+1] <= dv_nj[g];
			dv_sp[g+1] <= dv_sp[g];
			dv_oi[g+1] <= dv_oi[g];
			dv_oj[g+1] <= dv_oj[g];
			dv_k[g+1] <= dv_k[g];
		end
	end

	// Final stage: sign, saturation and the status code.
	localparam logic [QB-1:0] LIM = QB'(1) << (CW - 1);
	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
	// Minus one, clamped to the most negative code when it does not fit.
	localparam logic signed [CW-1:0] NEG_ONE = (FB >= CW - 1) ? MINV :
		CW'(-(longint'(1) << FB));

	logic sat_i, sat_j;
	logic signed [CW-1:0] ri_c, rj_c;
	always_comb begin
		sat_i = 1'b0;
		sat_j = 1'b0;
		if (dv_ni[NS]) begin
			sat_i = dv_oi[NS] || dv_qi[NS] > LIM;
			ri_c = sat_i ? MINV : CW'(-dv_qi[NS]);
		end else begin
			sat_i = dv_oi[NS] || dv_qi[NS] > LIM - 1'b1;
			ri_c = sat_i ? MAXV : CW'(dv_qi[NS]);
		end
		if (dv_nj[NS]) begin
			sat_j = dv_oj[NS] || dv_qj[NS] > LIM;
			rj_c = sat_j ? MINV : CW'(-dv_qj[NS]);
		end else begin
			sat_j = dv_oj[NS] || dv_qj[NS] > LIM - 1'b1;
			rj_c = sat_j ? MAXV : CW'(dv_qj[NS]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dv_v[NS];
		end
	end
	always_ff @(posedge clk) begin
		if (dv_sp[NS]) begin
			result.status <= pbary_pkg::status_t'(dv_k[NS]);
			if (dv_k[NS] == pbary_pkg::ST_CULLED) begin
				result.persp_i <= NEG_ONE;
				result.persp_j <= NEG_ONE;
			end else begin
				result.persp_i <= '0;
				result.persp_j <= '0;
			end
		end else begin
			result.persp_i <= ri_c;
			result.persp_j <= rj_c;
			result.status <= (sat_i || sat_j) ? pbary_pkg::ST_SAT : pbary_pkg::ST_OK;
		end
	end

`ifndef NO_ASSERTIONS
	// A valid leaving the last divider stage always reaches the result strobe register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[NS] |=> result_valid)
		else $error("result strobe lost in pipeline");
	// Culled results always carry minus one on both weights.
	a_cull: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == pbary_pkg::ST_CULLED) |->
		(result.persp_i == NEG_ONE && result.persp_j == NEG_ONE))
		else $error("culled result with wrong weights");
	// Degenerate results always carry zero weights.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == pbary_pkg::ST_DEGEN) |->
		(result.persp_i == '0 && result.persp_j == '0))
		else $error("degenerate result with nonzero weights");
	// Nothing comes out that did not go in.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(accept))
		else $error("stage one valid without a transfer");
`endif

endmodule
